@@ rtl/core/fmpc_pkg.sv @@
// fmpc_pkg: shared types, constants and helpers for the first-match pattern classifier
// used by fmpc_lane, fmpc_merge and first_match_pattern_classifier; no dependencies
package fmpc_pkg;

    // field widths of the transactions
    localparam int CODE_W  = 8;
    localparam int IN_CODES = 4;
    localparam int SLOT_W  = 4;
    localparam int GROUP_W = 4;
    localparam int COUNT_W = 20;
    localparam int LABEL_W = 21;

    // configuration register widths
    localparam int GROUP_COUNT_W  = 5;
    localparam int EQ_COUNT_W     = 3;
    localparam int CFG_DATA_W     = 5;
    localparam int CFG_IDX_W      = 2;

    // default table geometry
    localparam int DEF_MAX_GROUPS = 16;
    localparam int DEF_MAX_CODES  = 4;

    // reset values of the configuration registers
    localparam logic [GROUP_COUNT_W-1:0] RST_GROUP_COUNT  = 5'd1;
    localparam logic [EQ_COUNT_W-1:0]    RST_EQ_COUNT     = 3'd4;
    localparam logic                     RST_INDEX_OFFSET = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GROUP_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EQ_COUNT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_OFFSET = 2'd2;

    // command codes
    localparam logic CMD_LOAD     = 1'b0;
    localparam logic CMD_CLASSIFY = 1'b1;

    typedef logic [CODE_W-1:0] t_code;
    typedef logic [IN_CODES-1:0][CODE_W-1:0] t_codes;

    // input transaction
    typedef struct packed {
        logic              command;
        logic [SLOT_W-1:0] slot;
        t_code             code_0;
        t_code             code_1;
        t_code             code_2;
        t_code             code_3;
    } t_in;

    // result transaction
    typedef struct packed {
        logic               found;
        logic [GROUP_W-1:0] group;
        logic [LABEL_W-1:0] label;
    } t_out;

    // per-lane control from the top level
    typedef struct packed {
        logic                  write;
        logic                  active;
        logic [EQ_COUNT_W-1:0] eq_count;
    } t_lane_ctl;

    // gather the codes of a transaction into an indexed row
    function automatic t_codes codes_of(input t_in item);
        t_codes row;
        row[0] = item.code_0;
        row[1] = item.code_1;
        row[2] = item.code_2;
        row[3] = item.code_3;
        return row;
    endfunction

endpackage

@@ rtl/core/first_match_pattern_classifier.sv @@
// first_match_pattern_classifier: top level with config registers, lanes and merge stage
// depends on fmpc_pkg, fmpc_lane and fmpc_merge
//
// Usage: the input channel (i_in_valid / o_in_stall / i_in_item) carries load and
// classify transactions. A load writes the four codes into pattern slot i_in_item.slot
// and gives no result. A classify compares its first eq_count codes with the slots
// below group_count and returns one result on the output channel
// (o_out_valid / i_out_stall / o_out_item): found, lowest matching slot and the label
// (observation number plus index_offset).
// Throughput is one transaction per cycle while o_in_stall is low; a classify result
// passes the lane compare register and then the merge output register before it shows
// on o_out_valid. A load is visible to a classify accepted in the next cycle.
// While the receiver stalls, the output register holds and the compare register still
// takes one more classify; o_in_stall rises only when both are full.
// Synchronous reset empties both stages, clears the observation counter and restores
// group_count=1, eq_count=4, index_offset=1. Pattern slots are not cleared and must be
// loaded before they take part. Configuration is written through i_cfg_we / i_cfg_idx /
// i_cfg_data while no transaction is in flight.
module first_match_pattern_classifier #(
    parameter int MAX_GROUPS = fmpc_pkg::DEF_MAX_GROUPS,
    parameter int MAX_CODES  = fmpc_pkg::DEF_MAX_CODES
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [fmpc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [fmpc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  fmpc_pkg::t_in                   i_in_item,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output fmpc_pkg::t_out                  o_out_item
);

    localparam int ROW_CODES = (MAX_CODES < fmpc_pkg::IN_CODES) ? MAX_CODES
                                                                : fmpc_pkg::IN_CODES;

    logic [fmpc_pkg::GROUP_COUNT_W-1:0] r_group_count;
    logic [fmpc_pkg::EQ_COUNT_W-1:0]    r_eq_count;
    logic                               r_index_offset;
    logic [fmpc_pkg::COUNT_W-1:0]       r_obs_count;
    logic [fmpc_pkg::COUNT_W-1:0]       n_obs_count;

    logic                         r_a_valid;
    logic [MAX_GROUPS-1:0]        r_a_match;
    logic [fmpc_pkg::LABEL_W-1:0] r_a_label;
    logic [fmpc_pkg::LABEL_W-1:0] n_a_label;

    logic                  in_acc;
    logic                  in_classify;
    logic                  in_load;
    logic                  merge_ready;
    logic [MAX_GROUPS-1:0] lane_match;
    fmpc_pkg::t_codes      in_codes;

    assign in_acc      = i_in_valid && !o_in_stall;
    assign in_classify = in_acc && (i_in_item.command == fmpc_pkg::CMD_CLASSIFY);
    assign in_load     = in_acc && (i_in_item.command == fmpc_pkg::CMD_LOAD);
    assign in_codes    = fmpc_pkg::codes_of(i_in_item);
    assign o_in_stall  = r_a_valid && !merge_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_count  <= fmpc_pkg::RST_GROUP_COUNT;
            r_eq_count     <= fmpc_pkg::RST_EQ_COUNT;
            r_index_offset <= fmpc_pkg::RST_INDEX_OFFSET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                fmpc_pkg::CFG_GROUP_COUNT: begin
                    r_group_count <= i_cfg_data;
                end
                fmpc_pkg::CFG_EQ_COUNT: begin
                    r_eq_count <= i_cfg_data[fmpc_pkg::EQ_COUNT_W-1:0];
                end
                fmpc_pkg::CFG_INDEX_OFFSET: begin
                    r_index_offset <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    // one lane per pattern slot
    for (genvar g = 0; g < MAX_GROUPS; g++) begin : g_lane
        fmpc_pkg::t_lane_ctl ctl;

        assign ctl.write    = in_load && (int'(i_in_item.slot) == g);
        assign ctl.active   = int'(r_group_count) > g;
        assign ctl.eq_count = r_eq_count;

        fmpc_lane #(
            .ROW_CODES (ROW_CODES)
        ) u_lane (
            .i_clk   (i_clk),
            .i_ctl   (ctl),
            .i_codes (in_codes),
            .o_match (lane_match[g])
        );
    end

    // observation counter and label
    assign n_obs_count = r_obs_count + fmpc_pkg::COUNT_W'(1);
    assign n_a_label   = {1'b0, r_obs_count} + fmpc_pkg::LABEL_W'(r_index_offset);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_obs_count <= '0;
        end else if (in_classify) begin
            r_obs_count <= n_obs_count;
        end
    end

    // lane compare register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_a_valid <= in_classify;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_classify) begin
            r_a_match <= lane_match;
            r_a_label <= n_a_label;
        end
    end

    // merge and output register
    fmpc_merge #(
        .MAX_GROUPS (MAX_GROUPS)
    ) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_a_valid),
        .i_match (r_a_match),
        .i_label (r_a_label),
        .i_stall (i_out_stall),
        .o_ready (merge_ready),
        .o_valid (o_out_valid),
        .o_item  (o_out_item)
    );

    // a classify transaction always lands in the compare register
    a_classify_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_classify |=> r_a_valid)
        else $error("accepted classify did not reach the compare register");

    // counter advances exactly once per classify
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_classify |=> r_obs_count == $past(r_obs_count) + fmpc_pkg::COUNT_W'(1))
        else $error("observation counter did not advance on classify");

    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_classify |=> r_obs_count == $past(r_obs_count))
        else $error("observation counter moved without a classify");

    // a miss reports group zero
    a_miss_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.found) |-> o_out_item.group == '0)
        else $error("miss result carries a nonzero group");

endmodule

@@ rtl/core/fmpc_lane.sv @@
// fmpc_lane: one pattern slot, its stored row and the compare against an observation
// depends on fmpc_pkg
module fmpc_lane #(
    parameter int ROW_CODES = fmpc_pkg::DEF_MAX_CODES
) (
    input  logic                i_clk,
    input  fmpc_pkg::t_lane_ctl i_ctl,
    input  fmpc_pkg::t_codes    i_codes,
    output logic                o_match
);

    logic [ROW_CODES-1:0][fmpc_pkg::CODE_W-1:0] r_row;
    logic [ROW_CODES-1:0]                       diff;

    // pattern row store, undefined until loaded
    always_ff @(posedge i_clk) begin
        if (i_ctl.write) begin
            r_row <= i_codes[ROW_CODES-1:0];
        end
    end

    // per-code mismatch, masked beyond the compared prefix
    for (genvar j = 0; j < ROW_CODES; j++) begin : g_code
        localparam logic [fmpc_pkg::EQ_COUNT_W-1:0] J = fmpc_pkg::EQ_COUNT_W'(j);
        assign diff[j] = (J < i_ctl.eq_count) && (r_row[j] != i_codes[j]);
    end

    assign o_match = i_ctl.active && !(|diff);

endmodule

@@ rtl/core/fmpc_merge.sv @@
// fmpc_merge: picks the lowest matching lane and holds the result transaction
// depends on fmpc_pkg
module fmpc_merge #(
    parameter int MAX_GROUPS = fmpc_pkg::DEF_MAX_GROUPS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [MAX_GROUPS-1:0]        i_match,
    input  logic [fmpc_pkg::LABEL_W-1:0] i_label,
    input  logic                         i_stall,
    output logic                         o_ready,
    output logic                         o_valid,
    output fmpc_pkg::t_out               o_item
);

    logic           r_valid;
    fmpc_pkg::t_out r_item;
    fmpc_pkg::t_out n_item;

    // lowest set match bit wins
    always_comb begin
        n_item.found = |i_match;
        n_item.group = '0;
        n_item.label = i_label;
        for (int i = MAX_GROUPS - 1; i >= 0; i--) begin
            if (i_match[i]) begin
                n_item.group = fmpc_pkg::GROUP_W'(i);
            end
        end
    end

    assign o_ready = !r_valid || !i_stall;

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule
